/* rtl/nec_pkg.sv */
// shared constants and types for the nested envelope counter
`timescale 1ns / 1ps
package nec_pkg;
	localparam int MAX_PAIRS_DEF = 256;
	localparam int DIM_BITS_DEF  = 16;
	localparam int FIELD_BITS    = 16;
	localparam int COUNT_BITS    = 9;

	// controller to datapath commands
	typedef struct packed {
		logic store;      // write incoming pair at fill count
		logic drop;       // mark overflow
		logic sort_init;  // i <= 1
		logic sort_load;  // issue read of store[i]
		logic sort_key;   // key <= read data, j <= i, issue read of i-1
		logic sort_shift; // store[j] <= store[j-1], j--, issue read of j-1
		logic sort_place; // store[j] <= key, i++
		logic lis_init;   // i <= 0, chain <= 0
		logic lis_load;   // read pair i
		logic lis_start;  // lo <= 0, hi <= chain, capture height
		logic lis_probe;  // issue tail read at mid
		logic lis_step;   // narrow lo / hi
		logic lis_write;  // write tail, extend chain when lo == chain, i++
		logic result;     // load result register, clear counts
	} nec_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic full;       // fill count at capacity
		logic sort_more;  // i < count
		logic sort_move;  // j > 0 and key goes before store[j-1]
		logic lis_more;   // i < count
		logic lo_lt_hi;   // search still open
	} nec_sts_t;
endpackage

/* rtl/nested_envelope_count.sv */
// top level of the nested envelope counter
`timescale 1ns / 1ps
// channel   dir  signals                     contents
// s_axis    in   tvalid tready tdata tlast   tdata: doll_width, doll_height
// m_axis    out  tvalid tready tdata         tdata: nest_count, overflow
// pairs are loaded one per cycle while the controller is in its load state and
// the result slot is free; after the last pair the controller runs an
// insertion sort in the pair memory, then a lower-bound search per pair over
// the tail memory; each array has one read port and one write port
// arst_n clears counts and control; memories are not cleared
// the result register holds while m_axis_tready is low; the next set is taken
// once the result slot is free
module nested_envelope_count import nec_pkg::*; #(
	parameter int MAX_PAIRS = MAX_PAIRS_DEF,
	parameter int DIM_BITS  = DIM_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [15:0] doll_width, [31:16] doll_height
	input  logic        s_axis_tlast,  // last_doll
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata   // [8:0] nest_count, [9] overflow, rest zero
);
	nec_cmd_t cmd;
	nec_sts_t sts;
	logic [COUNT_BITS-1:0] res_count;
	logic                  res_over;

	// only the low DIM_BITS of each dimension take part
	nec_control u_ctl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_last(s_axis_tlast),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.sts(sts), .cmd(cmd)
	);

	nec_datapath #(.MAX_PAIRS(MAX_PAIRS), .DIM_BITS(DIM_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.in_w(s_axis_tdata[DIM_BITS-1:0]),
		.in_h(s_axis_tdata[FIELD_BITS+DIM_BITS-1:FIELD_BITS]),
		.res_count(res_count), .res_over(res_over)
	);

	assign m_axis_tdata = {6'b0, res_over, res_count};
endmodule

/* rtl/nec_datapath.sv */
// datapath: pair memory, tail memory, sort and search registers
`timescale 1ns / 1ps
module nec_datapath import nec_pkg::*; #(
	parameter int MAX_PAIRS = MAX_PAIRS_DEF,
	parameter int DIM_BITS  = DIM_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  nec_cmd_t              cmd,
	output nec_sts_t              sts,
	input  logic [DIM_BITS-1:0]   in_w,
	input  logic [DIM_BITS-1:0]   in_h,
	output logic [COUNT_BITS-1:0] res_count,
	output logic                  res_over
);
	localparam int AW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
	localparam int CW = $clog2(MAX_PAIRS + 1);

	logic [2*DIM_BITS-1:0] pair_mem [MAX_PAIRS];
	logic [DIM_BITS-1:0]   tail_mem [MAX_PAIRS];
	logic [2*DIM_BITS-1:0] prd_q;
	logic [DIM_BITS-1:0]   trd_q;
	logic [CW-1:0] count_q, chain_q, i_q, j_q, lo_q, hi_q;
	logic [2*DIM_BITS-1:0] key_q;
	logic [DIM_BITS-1:0]   h_q;
	logic                  drop_q;
	logic [CW-1:0]         mid;
	logic [CW-1:0]         jm1;
	logic [CW-1:0]         jm2;
	logic [CW-1:0]         im1;
	logic [AW-1:0]         praddr;
	logic [AW-1:0]         pwaddr;
	logic [2*DIM_BITS-1:0] pwdata;
	logic                  pwe;
	logic [DIM_BITS-1:0]   kw, kh, pw, ph;

	assign mid = lo_q + ((hi_q - lo_q) >> 1);
	assign jm1 = j_q - CW'(1);
	assign jm2 = jm1 - CW'(1);
	assign im1 = i_q - CW'(1);
	assign {kh, kw} = key_q;
	assign {ph, pw} = prd_q;

	always_comb begin
		pwe    = 1'b0;
		pwaddr = count_q[AW-1:0];
		pwdata = {in_h, in_w};
		if (cmd.store) begin
			pwe = 1'b1;
		end else if (cmd.sort_shift) begin
			pwe    = 1'b1;
			pwaddr = j_q[AW-1:0];
			pwdata = prd_q;
		end else if (cmd.sort_place) begin
			pwe    = 1'b1;
			pwaddr = j_q[AW-1:0];
			pwdata = key_q;
		end
		praddr = i_q[AW-1:0];
		if (cmd.sort_key) begin
			praddr = im1[AW-1:0];
		end else if (cmd.sort_shift) begin
			praddr = jm2[AW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (pwe) begin
			pair_mem[pwaddr] <= pwdata;
		end
		if (cmd.sort_load || cmd.sort_key || cmd.sort_shift || cmd.lis_load) begin
			prd_q <= pair_mem[praddr];
		end
		if (cmd.lis_write) begin
			tail_mem[lo_q[AW-1:0]] <= h_q;
		end
		if (cmd.lis_probe) begin
			trd_q <= tail_mem[mid[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			chain_q <= '0;
			drop_q  <= 1'b0;
			i_q     <= '0;
			j_q     <= '0;
			lo_q    <= '0;
			hi_q    <= '0;
			key_q   <= '0;
			h_q     <= '0;
			res_count <= '0;
			res_over  <= 1'b0;
		end else begin
			if (cmd.store) count_q <= count_q + CW'(1);
			if (cmd.drop) drop_q <= 1'b1;
			if (cmd.sort_init) i_q <= CW'(1);
			if (cmd.sort_key) begin
				key_q <= prd_q;
				j_q   <= i_q;
			end
			if (cmd.sort_shift) j_q <= jm1;
			if (cmd.sort_place) i_q <= i_q + CW'(1);
			if (cmd.lis_init) begin
				i_q     <= '0;
				chain_q <= '0;
			end
			if (cmd.lis_start) begin
				lo_q <= '0;
				hi_q <= chain_q;
				h_q  <= ph;
			end
			if (cmd.lis_step) begin
				if (trd_q < h_q) lo_q <= mid + CW'(1);
				else hi_q <= mid;
			end
			if (cmd.lis_write) begin
				if (lo_q == chain_q) chain_q <= chain_q + CW'(1);
				i_q <= i_q + CW'(1);
			end
			if (cmd.result) begin
				res_count <= COUNT_BITS'(chain_q);
				res_over  <= drop_q;
				count_q   <= '0;
				drop_q    <= 1'b0;
			end
		end
	end

	// prd_q holds store[j-1] during the sort compare
	always_comb begin
		sts.full      = (count_q == CW'(MAX_PAIRS));
		sts.sort_more = (i_q < count_q);
		sts.sort_move = (j_q != '0) &&
			((kw == pw) ? (ph < kh) : (kw < pw));
		sts.lis_more  = (i_q < count_q);
		sts.lo_lt_hi  = (lo_q < hi_q);
	end
endmodule

/* rtl/nec_control.sv */
// controller state machine for load, sort, chain and result phases
`timescale 1ns / 1ps
module nec_control import nec_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  logic     in_last,
	output logic     out_valid,
	input  logic     out_ready,
	input  nec_sts_t sts,
	output nec_cmd_t cmd
);
	localparam logic [3:0] S_LOAD  = 4'd0;
	localparam logic [3:0] S_SINIT = 4'd1;
	localparam logic [3:0] S_SLOAD = 4'd2;
	localparam logic [3:0] S_SCMP  = 4'd3;
	localparam logic [3:0] S_SKEY  = 4'd4;
	localparam logic [3:0] S_LINIT = 4'd5;
	localparam logic [3:0] S_LRD   = 4'd6;
	localparam logic [3:0] S_LST   = 4'd7;
	localparam logic [3:0] S_LPRB  = 4'd8;
	localparam logic [3:0] S_LSTEP = 4'd9;
	localparam logic [3:0] S_LWR   = 4'd10;
	localparam logic [3:0] S_RES   = 4'd11;

	logic [3:0] state_q, state_d;
	logic       ov_q;
	logic       acc;

	assign in_ready  = (state_q == S_LOAD) && !(ov_q && !out_ready);
	assign acc       = in_valid && in_ready;
	assign out_valid = ov_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_LOAD: begin
				if (acc) begin
					cmd.store = !sts.full;
					cmd.drop  = sts.full;
					if (in_last) state_d = S_SINIT;
				end
			end
			S_SINIT: begin
				cmd.sort_init = 1'b1;
				state_d = S_SLOAD;
			end
			S_SLOAD: begin
				if (sts.sort_more) begin
					cmd.sort_load = 1'b1;
					state_d = S_SKEY;
				end else begin
					state_d = S_LINIT;
				end
			end
			S_SKEY: begin
				cmd.sort_key = 1'b1;
				state_d = S_SCMP;
			end
			S_SCMP: begin
				if (sts.sort_move) begin
					cmd.sort_shift = 1'b1;
				end else begin
					cmd.sort_place = 1'b1;
					state_d = S_SLOAD;
				end
			end
			S_LINIT: begin
				cmd.lis_init = 1'b1;
				state_d = S_LRD;
			end
			S_LRD: begin
				if (sts.lis_more) begin
					cmd.lis_load = 1'b1;
					state_d = S_LST;
				end else begin
					state_d = S_RES;
				end
			end
			S_LST: begin
				cmd.lis_start = 1'b1;
				state_d = S_LPRB;
			end
			S_LPRB: begin
				if (sts.lo_lt_hi) begin
					cmd.lis_probe = 1'b1;
					state_d = S_LSTEP;
				end else begin
					state_d = S_LWR;
				end
			end
			S_LSTEP: begin
				cmd.lis_step = 1'b1;
				state_d = S_LPRB;
			end
			S_LWR: begin
				cmd.lis_write = 1'b1;
				state_d = S_LRD;
			end
			S_RES: begin
				if (!ov_q || out_ready) begin
					cmd.result = 1'b1;
					state_d = S_LOAD;
				end
			end
			default: state_d = S_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.result) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
		end
	end

`ifndef NO_ASSERTIONS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_LOAD) |-> !in_ready) else $error("accept while busy");
	a_result_raises: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.result |=> out_valid) else $error("result not shown");
	a_one_cmd_write: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({cmd.store, cmd.sort_shift, cmd.sort_place}) <= 1)
		else $error("pair memory write conflict");
`endif
endmodule

/* tb/sv/tb_nested_envelope_count.sv */
// self-checking testbench for the nested envelope counter
`timescale 1ns / 1ps
module tb_nested_envelope_count;
	import nec_pkg::*;

	localparam int CAP       = MAX_PAIRS_DEF;
	localparam int WATCHDOG  = 400000;   // idle cycles allowed
	localparam int RAND_ITEMS = 1320;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;   // [15:0] doll_width, [31:16] doll_height
	logic        s_axis_tlast;   // last_doll
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;   // [8:0] nest_count, [9] overflow

	nested_envelope_count DUT (.*);

	// one expected result per completed set
	typedef struct packed {
		logic [8:0] count;
		logic       ovf;
	} chain_result_t;

	// directed stimulus row; has_exp marks rows with a hand-typed expectation
	typedef struct {
		logic [15:0] w;
		logic [15:0] h;
		logic        last;
		logic        has_exp;
		logic [8:0]  exp_count;
		logic        exp_ovf;
	} doll_row_t;

	chain_result_t expected_chains[$];
	logic [15:0]   set_w[$];
	logic [15:0]   set_h[$];
	logic          set_dropped;
	int            mismatches;
	int            idle_cycles;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// longest strictly nested chain: width asc / height desc, then strict lis on heights
	function automatic chain_result_t nest_chain();
		logic [15:0] ws[$];
		logic [15:0] hs[$];
		logic [15:0] tails[$];
		logic [15:0] kw, kh;
		int j, lo, hi, mid;
		chain_result_t r;
		ws = set_w;
		hs = set_h;
		for (int i = 1; i < ws.size(); i++) begin
			kw = ws[i];
			kh = hs[i];
			j = i;
			while (j > 0 && ((kw == ws[j-1]) ? (hs[j-1] < kh) : (kw < ws[j-1]))) begin
				ws[j] = ws[j-1];
				hs[j] = hs[j-1];
				j--;
			end
			ws[j] = kw;
			hs[j] = kh;
		end
		for (int i = 0; i < hs.size(); i++) begin
			lo = 0;
			hi = tails.size();
			while (lo < hi) begin
				mid = lo + (hi - lo) / 2;
				if (tails[mid] < hs[i]) lo = mid + 1;
				else hi = mid;
			end
			if (lo == tails.size()) tails.insert(tails.size(), hs[i]);
			else tails[lo] = hs[i];
		end
		r.count = 9'(tails.size());
		r.ovf   = set_dropped;
		return r;
	endfunction

	// fold one accepted transaction into the open set
	task automatic absorb_doll(input logic [15:0] w, input logic [15:0] h, input logic last);
		if (set_w.size() < CAP) begin
			set_w.insert(set_w.size(), w);
			set_h.insert(set_h.size(), h);
		end else begin
			set_dropped = 1'b1;
		end
		if (last) begin
			expected_chains.insert(expected_chains.size(), nest_chain());
			set_w.delete();
			set_h.delete();
			set_dropped = 1'b0;
		end
	endtask

	// drive one transaction after a random gap and wait for its handshake
	task automatic send_doll(input logic [15:0] w, input logic [15:0] h, input logic last);
		int gap;
		gap = $urandom_range(0, 14);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {h, w};
		s_axis_tlast  <= last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		absorb_doll(w, h, last);
	endtask

	task automatic send_checked(input doll_row_t row);
		int before_n;
		chain_result_t typed;
		before_n = expected_chains.size();
		send_doll(row.w, row.h, row.last);
		// typed-in value must agree with the predictor
		if (row.has_exp && expected_chains.size() > before_n) begin
			typed.count = row.exp_count;
			typed.ovf   = row.exp_ovf;
			if (expected_chains[$] != typed) begin
				mismatches++;
				if (mismatches <= 10)
					$display("table row mismatch: typed %0d/%0d predicted %0d/%0d",
						typed.count, typed.ovf, expected_chains[$].count,
						expected_chains[$].ovf);
			end
		end
	endtask

	// sink side: random stalls, compare against the oldest expectation
	initial begin
		int stall;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = $urandom_range(0, 14);
			if ($urandom_range(0, 3) == 0) stall = 0;
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
			if (expected_chains.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: count %0d overflow %0b",
						m_axis_tdata[8:0], m_axis_tdata[9]);
			end else begin
				chain_result_t e;
				e = expected_chains.pop_front();
				if (m_axis_tdata[8:0] !== e.count || m_axis_tdata[9] !== e.ovf ||
					m_axis_tdata[15:10] !== 6'd0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: expected count %0d overflow %0b, got %0d %0b (pad %h)",
							e.count, e.ovf, m_axis_tdata[8:0], m_axis_tdata[9],
							m_axis_tdata[15:10]);
				end
			end
		end
	end

	// watchdog: cycles with no transaction on either side
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG) begin
				$display("** nested_envelope_count: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		doll_row_t table_rows[$];
		doll_row_t row;
		int n, kind, sent;
		logic [15:0] w, h, base;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		arst_n        = 1'b0;
		mismatches    = 0;
		set_dropped   = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table: w, h, last, typed?, count, overflow
		table_rows = '{
			'{16'h0000, 16'h0000, 1'b1, 1'b1, 9'd1, 1'b0},  // single pair right after reset
			'{16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 9'd1, 1'b0},  // extremes
			'{16'h0005, 16'h0005, 1'b0, 1'b0, 9'd0, 1'b0},  // equal envelopes never nest
			'{16'h0005, 16'h0005, 1'b1, 1'b1, 9'd1, 1'b0},
			'{16'h0007, 16'h0001, 1'b0, 1'b0, 9'd0, 1'b0},  // equal widths never nest
			'{16'h0007, 16'h0009, 1'b0, 1'b0, 9'd0, 1'b0},
			'{16'h0007, 16'h0004, 1'b1, 1'b1, 9'd1, 1'b0},
			'{16'h0000, 16'h0000, 1'b0, 1'b0, 9'd0, 1'b0},  // full chain 0..ffff
			'{16'h5555, 16'hAAAA, 1'b0, 1'b0, 9'd0, 1'b0},
			'{16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 9'd3, 1'b0},
			'{16'h0003, 16'h0008, 1'b0, 1'b0, 9'd0, 1'b0},  // mixed, predictor only
			'{16'h0001, 16'h0002, 1'b0, 1'b0, 9'd0, 1'b0},
			'{16'h0002, 16'h0009, 1'b0, 1'b0, 9'd0, 1'b0},
			'{16'hAAAA, 16'h5555, 1'b0, 1'b0, 9'd0, 1'b0},
			'{16'h0004, 16'h0003, 1'b1, 1'b0, 9'd0, 1'b0}
		};
		foreach (table_rows[i]) send_checked(table_rows[i]);

		// store full: 256 increasing pairs then 3 dropped ones, last one dropped too
		for (int i = 0; i < CAP + 3; i++) begin
			row = '{i[15:0], i[15:0], (i == CAP + 2), (i == CAP + 2), 9'd256, 1'b1};
			send_checked(row);
		end
		// exactly at capacity, nothing dropped, all equal widths
		for (int i = 0; i < CAP; i++) begin
			row = '{16'h1234, i[15:0], (i == CAP - 1), (i == CAP - 1), 9'd1, 1'b0};
			send_checked(row);
		end

		// random sets, mostly small
		sent = 0;
		while (sent < RAND_ITEMS) begin
			kind = $urandom_range(0, 9);
			n = (kind == 0) ? $urandom_range(100, 300) : $urandom_range(1, 24);
			base = 16'($urandom);
			for (int i = 0; i < n; i++) begin
				case ($urandom_range(0, 3))
					0: begin
						w = 16'($urandom);
						h = 16'($urandom);
					end
					1: begin  // narrow range: many ties
						w = 16'($urandom_range(0, 7));
						h = 16'($urandom_range(0, 7));
					end
					2: begin  // mostly nesting
						w = 16'(base + i * 3 + $urandom_range(0, 4));
						h = 16'(base + i * 2 + $urandom_range(0, 5));
					end
					default: begin  // corners
						w = 16'($urandom_range(0, 1) ? 16'hFFFF - $urandom_range(0, 3) :
							$urandom_range(0, 3));
						h = 16'($urandom_range(0, 1) ? 16'hFFFF - $urandom_range(0, 3) :
							$urandom_range(0, 3));
					end
				endcase
				send_doll(w, h, i == n - 1);
			end
			sent += n;
		end
		s_axis_tvalid <= 1'b0;
		s_axis_tlast  <= 1'b0;

		// drain, bounded by the watchdog, then settle
		while (expected_chains.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (mismatches == 0)
			$display("** nested_envelope_count: PASSED **");
		else
			$display("** nested_envelope_count: FAILED **");
		$finish;
	end
endmodule

/* sim.f */
rtl/nec_pkg.sv
rtl/nec_datapath.sv
rtl/nec_control.sv
rtl/nested_envelope_count.sv
tb/sv/tb_nested_envelope_count.sv
